FILE: src/uqpd_pkg.sv
// Shared types, codes and helper functions of the URL query percent decoder.
package uqpd_pkg;

    // Most results that one raw byte can produce.
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_W = $clog2(MAX_RESULTS);
    localparam int COUNT_W = $clog2(MAX_RESULTS + 1);

    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Result kinds.
    localparam logic [2:0] KIND_PATH     = 3'd0;
    localparam logic [2:0] KIND_KEY      = 3'd1;
    localparam logic [2:0] KIND_VALUE    = 3'd2;
    localparam logic [2:0] KIND_PATH_END = 3'd3;
    localparam logic [2:0] KIND_PAIR_END = 3'd4;

    // Character codes.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h66;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;
    localparam logic [3:0] HEX_TEN    = 4'd10;

    // Input item.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    // Result item.
    typedef struct packed {
        logic [2:0] out_kind;
        logic [7:0] out_byte;
        logic       pair_kept;
        logic       item_last;
        logic       string_done;
    } out_t;

    // One result as stored in a bundle.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       kept;
    } slot_t;

    // All results caused by one raw byte.
    typedef struct packed {
        logic                          last;
        logic [COUNT_W-1:0]            count;
        slot_t [MAX_RESULTS-1:0]       slot;
    } bundle_t;

    // True for an ASCII hex digit.
    function automatic logic hex_ok(logic [7:0] c);
        return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
               ((c >= CH_LA) && (c <= CH_LF)) ||
               ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    // Value of an ASCII hex digit; zero for anything else.
    function automatic logic [3:0] hex_val(logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            v = c[3:0];
        end else if ((c >= CH_LA) && (c <= CH_LF)) begin
            v = 4'(c - CH_LA) + HEX_TEN;
        end else if ((c >= CH_UA) && (c <= CH_UF)) begin
            v = 4'(c - CH_UA) + HEX_TEN;
        end
        return v;
    endfunction

    // Appends one result to a bundle; a full bundle is left as it is.
    function automatic bundle_t push_result(bundle_t b, logic [2:0] kind,
                                            logic [7:0] data, logic kept);
        bundle_t r;
        r = b;
        if (b.count < COUNT_W'(MAX_RESULTS)) begin
            r.slot[b.count[SLOT_W-1:0]] = '{kind: kind, data: data, kept: kept};
            r.count = b.count + COUNT_W'(1);
        end
        return r;
    endfunction

endpackage

FILE: src/uqpd_front.sv
// Front part: accepts raw bytes, runs the parse state and forms result bundles.
module uqpd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_data,
    input  logic             in_valid,
    input  uqpd_pkg::in_t    in_item,
    input  logic             q_full,
    output logic             q_push,
    output uqpd_pkg::bundle_t q_bundle
);
    import uqpd_pkg::*;

    // Parse phase codes.
    localparam logic [1:0] PH_PATH  = 2'd0;
    localparam logic [1:0] PH_KEY   = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    // Escape progress codes.
    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    logic       mode_reg;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] esc_reg, esc_next;
    logic [7:0] held_reg, held_next;
    logic       start_reg, start_next;
    logic       key_ne_reg, key_ne_next;
    logic       saw_eq_reg, saw_eq_next;

    logic       accept;
    logic       skip;
    logic       redo;
    logic [2:0] kind;
    logic [7:0] c;
    bundle_t    b;

    assign accept = in_valid && !q_full;
    assign c = in_item.in_byte;

    // Next state and results of one raw byte.
    always_comb
    begin
        phase_next  = phase_reg;
        esc_next    = esc_reg;
        held_next   = held_reg;
        start_next  = start_reg;
        key_ne_next = key_ne_reg;
        saw_eq_next = saw_eq_reg;
        b           = '0;
        skip        = 1'b0;
        redo        = 1'b0;

        // The mode is sampled on the first byte of each string.
        if (start_reg)
        begin
            phase_next = mode_reg ? PH_KEY : PH_PATH;
            start_next = 1'b0;
            skip = mode_reg && (c == CH_QMARK);
        end
        kind = (phase_next == PH_KEY) ? KIND_KEY : KIND_VALUE;

        if (skip)
        begin
            // A leading question mark in query mode is dropped.
        end
        else if (phase_next == PH_PATH)
        begin
            if (c == CH_QMARK)
            begin
                b = push_result(b, KIND_PATH_END, 8'd0, 1'b0);
                phase_next = PH_KEY;
            end
            else
            begin
                b = push_result(b, KIND_PATH, c, 1'b0);
            end
        end
        else if (c == CH_AMP || (c == CH_EQUALS && phase_next == PH_KEY))
        begin
            // Boundaries flush any pending escape literally.
            if (esc_next != ESC_NONE)
            begin
                b = push_result(b, kind, CH_PERCENT, 1'b0);
            end
            if (esc_next == ESC_DIGIT)
            begin
                b = push_result(b, kind, held_next, 1'b0);
            end
            esc_next = ESC_NONE;
            if (c == CH_AMP)
            begin
                b = push_result(b, KIND_PAIR_END, 8'd0, saw_eq_next & key_ne_next);
                phase_next  = PH_KEY;
                key_ne_next = 1'b0;
                saw_eq_next = 1'b0;
            end
            else
            begin
                saw_eq_next = 1'b1;
                phase_next  = PH_VALUE;
            end
        end
        else
        begin
            if (phase_next == PH_KEY)
            begin
                key_ne_next = 1'b1;
            end
            redo = 1'b1;
            // Percent escape decoding; a bad digit flushes and rehandles the byte.
            if (esc_next == ESC_PCT)
            begin
                if (hex_ok(c))
                begin
                    held_next = c;
                    esc_next  = ESC_DIGIT;
                    redo      = 1'b0;
                end
                else
                begin
                    b = push_result(b, kind, CH_PERCENT, 1'b0);
                    esc_next = ESC_NONE;
                end
            end
            else if (esc_next == ESC_DIGIT)
            begin
                if (hex_ok(c))
                begin
                    b = push_result(b, kind, {hex_val(held_next), hex_val(c)}, 1'b0);
                    esc_next  = ESC_NONE;
                    held_next = 8'd0;
                    redo      = 1'b0;
                end
                else
                begin
                    b = push_result(b, kind, CH_PERCENT, 1'b0);
                    b = push_result(b, kind, held_next, 1'b0);
                    esc_next = ESC_NONE;
                end
            end
            if (redo)
            begin
                if (c == CH_PERCENT)
                begin
                    esc_next = ESC_PCT;
                end
                else if (c == CH_PLUS)
                begin
                    b = push_result(b, kind, CH_SPACE, 1'b0);
                end
                else
                begin
                    b = push_result(b, kind, c, 1'b0);
                end
            end
        end

        // End of string: close the path or the open pair, then restart.
        if (in_item.in_last)
        begin
            kind = (phase_next == PH_KEY) ? KIND_KEY : KIND_VALUE;
            if (phase_next == PH_PATH)
            begin
                b = push_result(b, KIND_PATH_END, 8'd0, 1'b0);
            end
            else
            begin
                if (esc_next != ESC_NONE)
                begin
                    b = push_result(b, kind, CH_PERCENT, 1'b0);
                end
                if (esc_next == ESC_DIGIT)
                begin
                    b = push_result(b, kind, held_next, 1'b0);
                end
                if (key_ne_next || saw_eq_next)
                begin
                    b = push_result(b, KIND_PAIR_END, 8'd0, saw_eq_next & key_ne_next);
                end
            end
            if (b.count == '0)
            begin
                b = push_result(b, KIND_PAIR_END, 8'd0, 1'b0);
            end
            phase_next  = mode_reg ? PH_KEY : PH_PATH;
            esc_next    = ESC_NONE;
            held_next   = 8'd0;
            start_next  = 1'b1;
            key_ne_next = 1'b0;
            saw_eq_next = 1'b0;
        end
        b.last = in_item.in_last;
    end

    assign q_push   = accept && (b.count != '0);
    assign q_bundle = b;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_data;
        end
    end

    // Parse state advances on every input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PATH;
            esc_reg    <= ESC_NONE;
            held_reg   <= 8'd0;
            start_reg  <= 1'b1;
            key_ne_reg <= 1'b0;
            saw_eq_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            esc_reg    <= esc_next;
            held_reg   <= held_next;
            start_reg  <= start_next;
            key_ne_reg <= key_ne_next;
            saw_eq_reg <= saw_eq_next;
        end
    end

endmodule

FILE: src/uqpd_queue.sv
// Small bundle queue that decouples the front from the back.
module uqpd_queue #(
    parameter int DEPTH = uqpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  uqpd_pkg::bundle_t push_data,
    input  logic              pop,
    output uqpd_pkg::bundle_t head,
    output logic              full,
    output logic              empty
);
    import uqpd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t        entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Bundle storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/uqpd_back.sv
// Back part: unpacks bundles into one result transfer per cycle unless stalled.
module uqpd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  uqpd_pkg::bundle_t head,
    input  logic              empty,
    output logic              pop,
    input  logic              out_stall,
    output logic              out_valid,
    output uqpd_pkg::out_t    out_item
);
    import uqpd_pkg::*;

    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              valid_reg, valid_next;
    out_t              item_reg, item_next;
    logic              load;
    logic              last_slot;
    slot_t             cur;

    assign load      = !empty && (!valid_reg || !out_stall);
    assign cur       = head.slot[idx_reg];
    assign last_slot = ({1'b0, idx_reg} + COUNT_W'(1)) == head.count;
    assign pop       = load && last_slot;

    // Select the next result and step through the bundle.
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        item_next  = item_reg;
        if (load)
        begin
            valid_next            = 1'b1;
            item_next.out_kind    = cur.kind;
            item_next.out_byte    = cur.data;
            item_next.pair_kept   = cur.kept;
            item_next.item_last   = last_slot;
            item_next.string_done = last_slot && head.last;
            idx_next = last_slot ? '0 : idx_reg + SLOT_W'(1);
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: src/url_query_percent_decoder_top.sv
// Top level of the URL query percent decoder.
// The first result of a byte is written into the bundle queue and then into the output
// register of the back part, from which it is offered.
// One input byte per cycle while the queue is not full; a byte that yields several results
// holds the output until all are sent; the queue absorbs such bursts until it fills.
// Reset clears the parse state, the queue and the output, and sets the query mode to 0.
module url_query_percent_decoder_top #(
    parameter int QUEUE_DEPTH = uqpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_data,
    input  logic           in_valid,
    output logic           in_stall,
    input  uqpd_pkg::in_t  in_item,
    output logic           out_valid,
    input  logic           out_stall,
    output uqpd_pkg::out_t out_item
);
    import uqpd_pkg::*;

    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    bundle_t q_bundle;
    bundle_t q_head;

    assign in_stall = q_full;

    // Parse and classify.
    uqpd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_item  (in_item),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_bundle (q_bundle)
    );

    // Decoupling queue.
    uqpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_bundle),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Serialize results.
    uqpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

FILE: src/uqpd_checker.sv
// Port-level checker for the URL query percent decoder, with its bind.
module uqpd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_stall,
    input uqpd_pkg::out_t out_item
);
    import uqpd_pkg::*;

    // A stalled result transfer holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // The end of a string is also the end of its byte's results.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.string_done |-> out_item.item_last)
        else $error("string_done without item_last");

    // Markers carry no byte.
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.out_kind == KIND_PATH_END ||
                      out_item.out_kind == KIND_PAIR_END) |-> out_item.out_byte == 8'd0)
        else $error("marker with nonzero byte");

    // Only a pair end can report a kept pair.
    a_kept_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.pair_kept |-> out_item.out_kind == KIND_PAIR_END)
        else $error("pair_kept on a non pair end");

    // A path end never follows itself without a string end between them.
    a_path_end_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_item.out_kind == KIND_PATH_END &&
        !out_item.string_done |=> !(out_valid && out_item.out_kind == KIND_PATH_END))
        else $error("back to back path ends");

endmodule

bind url_query_percent_decoder_top uqpd_checker u_uqpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
